@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low reset).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/tacq_pkg.sv @@
// ---------------------------------------------------------------------------
// tacq_pkg
// Shared constants and the result payload layout of the triangle angle core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tacq_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int N_COORDS        = 9;   // three corners, xyz each
    localparam int QUOT_BITS       = 17;  // quotient bits of every divider
    localparam int COS_FRAC        = 15;
    localparam int RATIO_FRAC      = 16;
    localparam int COS_POS_MAX     = 32767;
    localparam int COS_NEG_MAX     = 32768;
    localparam int RATIO_MAX       = 65535;

    // result tdata, lowest field last in the declaration
    typedef struct packed {
        logic [15:0] edge_ratio;
        logic [15:0] max_cosine;
        logic [15:0] min_cosine;
    } t_out_data;

endpackage

@@ src/triangle_angle_quality_core.sv @@
// ---------------------------------------------------------------------------
// triangle_angle_quality_core
// Pipelined triangle quality kernel: min/max interior angle cosine (Q1.15)
// and shortest/longest edge ratio (Q0.16) from three Q16.16 corners.
// ---------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser
// s_*     | in  | p0_x,p0_y,p0_z,p1_x,..,p2_z (CW bits ea)| -
// m_*     | out | min_cosine, max_cosine, edge_ratio      | degenerate
//
// One triangle per cycle sustained while the output is not stalled; the pipe
// depth is set by the bit-per-stage square root (CW+1 stages)
// and the 17-stage restoring dividers.
// Reset clears all stage valid bits; payload registers are not reset.
// The whole pipe advances when the output register is empty or taken, so a
// stalled transfer freezes every stage and nothing is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_angle_quality_core
    import tacq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, zero pad
    input  logic [((N_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // min_cosine [15:0], max_cosine [31:16], edge_ratio [47:32]
    output logic [47:0] m_tdata,
    // degenerate
    output logic m_tuser,
    output logic m_tvalid,
    input  logic m_tready
);

    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;           // edge component
    localparam int PW  = 2 * EW;          // component product
    localparam int SW  = 2 * W + 2;       // squared length
    localparam int DW  = 2 * W + 3;       // signed dot product
    localparam int LW  = W + 1;           // edge length
    localparam int RMW = LW + 2;          // square root remainder
    localparam int QB  = QUOT_BITS;
    localparam int RW  = 2 * W + 2 + QB + 1; // divider remainder

    // global advance: output slot free or being drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: edge vectors ----------------
    // e01 in [0..2], e02 in [3..5], e12 in [6..8]
    logic signed [EW-1:0] n1_e [9];
    logic signed [EW-1:0] r1_e [9];
    logic                 r1_v;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_e[c]   = EW'($signed(s_tdata[(3+c)*W +: W])) - EW'($signed(s_tdata[c*W +: W]));
            n1_e[3+c] = EW'($signed(s_tdata[(6+c)*W +: W])) - EW'($signed(s_tdata[c*W +: W]));
            n1_e[6+c] = EW'($signed(s_tdata[(6+c)*W +: W]))
                      - EW'($signed(s_tdata[(3+c)*W +: W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_tvalid;
        end
        if (en) begin
            r1_e <= n1_e;
        end
    end

    // ---------------- stage 2: component products ----------------
    logic signed [PW-1:0] r2_sq [9];
    logic signed [PW-1:0] r2_dp [9];   // dot d0, d1, d2 components
    logic                 r2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r2_sq[i] <= r1_e[i] * r1_e[i];
            end
            for (int c = 0; c < 3; c++) begin
                r2_dp[c]   <= r1_e[c]   * r1_e[3+c];
                r2_dp[3+c] <= r1_e[c]   * r1_e[6+c];
                r2_dp[6+c] <= r1_e[3+c] * r1_e[6+c];
            end
        end
    end

    // ---------------- stage 3: sums ----------------
    logic [SW-1:0]        n3_s [3];
    logic signed [DW-1:0] n3_d [3];
    logic [SW-1:0]        r3_s [3];
    logic signed [DW-1:0] r3_d [3];
    logic                 r3_dg;
    logic                 r3_v;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            n3_s[e] = r2_sq[3*e][SW-1:0] + r2_sq[3*e+1][SW-1:0] + r2_sq[3*e+2][SW-1:0];
            n3_d[e] = DW'(r2_dp[3*e]) + DW'(r2_dp[3*e+1]) + DW'(r2_dp[3*e+2]);
        end
        // angle at p1 uses the reversed first edge
        n3_d[1] = -n3_d[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_s  <= n3_s;
            r3_d  <= n3_d;
            r3_dg <= (n3_s[0] == '0) || (n3_s[1] == '0) || (n3_s[2] == '0);
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    logic [SW-1:0]        r_sq_s    [LW][3];
    logic [RMW-1:0]       r_sq_rem  [LW][3];
    logic [LW-1:0]        r_sq_root [LW][3];
    logic signed [DW-1:0] r_sq_d    [LW][3];
    logic                 r_sq_dg   [LW];
    logic                 r_sq_v    [LW];

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        localparam int BI = LW - 1 - k;
        logic [SW-1:0]        p_s    [3];
        logic [RMW-1:0]       p_rem  [3];
        logic [LW-1:0]        p_root [3];
        logic signed [DW-1:0] p_d    [3];
        logic                 p_dg;
        logic                 p_v;
        logic [RMW+1:0]       t_rem  [3];
        logic [RMW+1:0]       t_try  [3];

        if (k == 0) begin : g_first
            always_comb begin
                p_s    = r3_s;
                p_d    = r3_d;
                p_dg   = r3_dg;
                p_v    = r3_v;
                for (int e = 0; e < 3; e++) begin
                    p_rem[e]  = '0;
                    p_root[e] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                p_s    = r_sq_s[k-1];
                p_rem  = r_sq_rem[k-1];
                p_root = r_sq_root[k-1];
                p_d    = r_sq_d[k-1];
                p_dg   = r_sq_dg[k-1];
                p_v    = r_sq_v[k-1];
            end
        end

        always_comb begin
            for (int e = 0; e < 3; e++) begin
                t_rem[e] = {p_rem[e], p_s[e][2*BI +: 2]};
                t_try[e] = (RMW+2)'({p_root[e], 2'b01});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= p_v;
            end
            if (en) begin
                r_sq_s[k]  <= p_s;
                r_sq_d[k]  <= p_d;
                r_sq_dg[k] <= p_dg;
                for (int e = 0; e < 3; e++) begin
                    if (t_rem[e] >= t_try[e]) begin
                        r_sq_rem[k][e]  <= RMW'(t_rem[e] - t_try[e]);
                        r_sq_root[k][e] <= {p_root[e][LW-2:0], 1'b1};
                    end else begin
                        r_sq_rem[k][e]  <= RMW'(t_rem[e]);
                        r_sq_root[k][e] <= {p_root[e][LW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- stage D: divider operands ----------------
    // divisions 0..2 are the corner cosines, 3 is the edge ratio
    logic [LW-1:0]        ln [3];
    logic [LW-1:0]        n_lmin, n_lmax;
    logic [DW-1:0]        n_mag [3];
    logic [RW-1:0]        rD_num [4];
    logic [RW-1:0]        rD_den [4];
    logic                 rD_neg [3];
    logic                 rD_dg;
    logic                 rD_v;

    always_comb begin
        ln = r_sq_root[LW-1];
        for (int e = 0; e < 3; e++) begin
            n_mag[e] = r_sq_d[LW-1][e][DW-1] ? DW'(-r_sq_d[LW-1][e])
                                              : DW'(r_sq_d[LW-1][e]);
        end
        n_lmin = (ln[0] < ln[1]) ? ln[0] : ln[1];
        if (ln[2] < n_lmin) n_lmin = ln[2];
        n_lmax = (ln[0] > ln[1]) ? ln[0] : ln[1];
        if (ln[2] > n_lmax) n_lmax = ln[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_v <= 1'b0;
        end else if (en) begin
            rD_v <= r_sq_v[LW-1];
        end
        if (en) begin
            rD_dg     <= r_sq_dg[LW-1];
            for (int e = 0; e < 3; e++) begin
                rD_num[e] <= RW'(n_mag[e]) << COS_FRAC;
                rD_neg[e] <= r_sq_d[LW-1][e][DW-1];
            end
            rD_den[0] <= RW'(ln[0] * ln[1]);
            rD_den[1] <= RW'(ln[0] * ln[2]);
            rD_den[2] <= RW'(ln[1] * ln[2]);
            rD_num[3] <= RW'(n_lmin) << RATIO_FRAC;
            rD_den[3] <= RW'(n_lmax);
        end
    end

    // ---------------- restoring dividers: one quotient bit per stage ----------------
    logic [RW-1:0] r_dv_rem [QB][4];
    logic [RW-1:0] r_dv_den [QB][4];
    logic [QB-1:0] r_dv_q   [QB][4];
    logic          r_dv_neg [QB][3];
    logic          r_dv_dg  [QB];
    logic          r_dv_v   [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int QI = QB - 1 - j;
        logic [RW-1:0] p_rem [4];
        logic [RW-1:0] p_den [4];
        logic [QB-1:0] p_q   [4];
        logic          p_neg [3];
        logic          p_dg;
        logic          p_v;
        logic [RW-1:0] t_sh  [4];

        if (j == 0) begin : g_first
            always_comb begin
                p_rem = rD_num;
                p_den = rD_den;
                p_neg = rD_neg;
                p_dg  = rD_dg;
                p_v   = rD_v;
                for (int i = 0; i < 4; i++) p_q[i] = '0;
            end
        end else begin : g_next
            always_comb begin
                p_rem = r_dv_rem[j-1];
                p_den = r_dv_den[j-1];
                p_q   = r_dv_q[j-1];
                p_neg = r_dv_neg[j-1];
                p_dg  = r_dv_dg[j-1];
                p_v   = r_dv_v[j-1];
            end
        end

        always_comb begin
            for (int i = 0; i < 4; i++) t_sh[i] = p_den[i] << QI;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= p_v;
            end
            if (en) begin
                r_dv_den[j] <= p_den;
                r_dv_neg[j] <= p_neg;
                r_dv_dg[j]  <= p_dg;
                for (int i = 0; i < 4; i++) begin
                    if (p_rem[i] >= t_sh[i]) begin
                        r_dv_rem[j][i] <= p_rem[i] - t_sh[i];
                        r_dv_q[j][i]   <= p_q[i] | (QB'(1) << QI);
                    end else begin
                        r_dv_rem[j][i] <= p_rem[i];
                        r_dv_q[j][i]   <= p_q[i];
                    end
                end
            end
        end
    end

    // ---------------- output stage: saturate, min/max, zero on degenerate ----------------
    logic [QB-1:0]      fq [4];
    logic [QB-1:0]      fm [3];
    logic signed [15:0] cv [3];
    logic signed [15:0] n_cmin, n_cmax;
    logic [15:0]        n_ratio;
    t_out_data          n_od;
    t_out_data          r_od;
    logic               r_odg;
    logic               r_ov;

    always_comb begin
        fq = r_dv_q[QB-1];
        for (int e = 0; e < 3; e++) begin
            if (r_dv_neg[QB-1][e]) begin
                fm[e] = (fq[e] > QB'(COS_NEG_MAX)) ? QB'(COS_NEG_MAX) : fq[e];
                cv[e] = 16'(QB'(0) - fm[e]);
            end else begin
                fm[e] = (fq[e] > QB'(COS_POS_MAX)) ? QB'(COS_POS_MAX) : fq[e];
                cv[e] = 16'(fm[e]);
            end
        end
        n_cmin = (cv[0] < cv[1]) ? cv[0] : cv[1];
        if (cv[2] < n_cmin) n_cmin = cv[2];
        n_cmax = (cv[0] > cv[1]) ? cv[0] : cv[1];
        if (cv[2] > n_cmax) n_cmax = cv[2];
        n_ratio = (fq[3] > QB'(RATIO_MAX)) ? 16'(RATIO_MAX) : 16'(fq[3]);
        if (r_dv_dg[QB-1]) begin
            n_od = '0;
        end else begin
            n_od.min_cosine = n_cmin;
            n_od.max_cosine = n_cmax;
            n_od.edge_ratio = n_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv_v[QB-1];
        end
        if (en) begin
            r_od  <= n_od;
            r_odg <= r_dv_dg[QB-1];
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_od;
    assign m_tuser  = r_odg;

endmodule

@@ src/tacq_checker.sv @@
// ---------------------------------------------------------------------------
// tacq_checker
// Port-level checks of the triangle angle core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tacq_checker
    import tacq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    t_out_data od;
    assign od = m_tdata;

    // a stalled result holds
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // reset empties the pipe
    `ASSERT_CLK_NR(a_rst, i_clk, !i_rst_n |=> !m_tvalid, "result valid after reset")

    // empty output slot never back-pressures the input
    `ASSERT_CLK(a_rdy, i_clk, i_rst_n, !m_tvalid |-> s_tready, "input stalled with empty output")

    // degenerate triangles report zero fields
    `ASSERT_CLK(a_dgz, i_clk, i_rst_n, m_tvalid && m_tuser |-> m_tdata == '0, "degenerate fields not zero")

    // min cosine never above max cosine
    `ASSERT_CLK(a_ord, i_clk, i_rst_n, m_tvalid |-> $signed(od.min_cosine) <= $signed(od.max_cosine), "min cosine above max")

endmodule

bind triangle_angle_quality_core tacq_checker u_tacq_checker (.*);
